// ===== hw/rtl/gpnwk_pkg.sv =====
// ----------------------------------------------------------------------------
// gpnwk_pkg
// Types, codes and helpers shared by the Green Power network frame parser.
// ----------------------------------------------------------------------------
package gpnwk_pkg;

  localparam int unsigned ResQDepth = 4;

  localparam logic [1:0] GpVersion       = 2'd3;
  localparam logic [1:0] GpDataFrame     = 2'd0;
  localparam logic [1:0] GpMaintFrame    = 2'd1;
  localparam int unsigned ExtFlagBit     = 7;

  localparam logic [2:0] AppIdZero       = 3'd0;
  localparam logic [2:0] AppIdTwo        = 3'd2;
  localparam logic [1:0] SecLevelCounter = 2'd2;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusBadType   = 3'd1;
  localparam logic [2:0] StatusBadVer    = 3'd2;
  localparam logic [2:0] StatusBadApp    = 3'd3;
  localparam logic [2:0] StatusTrunc     = 3'd4;

  localparam logic       KindPayload     = 1'b0;
  localparam logic       KindSummary     = 1'b1;

  typedef enum logic [3:0] {
    PhFc      = 4'd0,
    PhExt     = 4'd1,
    PhSrc     = 4'd2,
    PhCnt     = 4'd3,
    PhCmd     = 4'd4,
    PhPayload = 4'd5,
    PhDone    = 4'd6,
    PhSkip    = 4'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  frame_control;
    logic [7:0]  ext_control;
    logic [31:0] source_id;
    logic [31:0] frame_counter;
    logic [7:0]  command_id;
  } out_item_t;

  // up to two result items per input item, packed in order
  typedef struct packed {
    logic [1:0] num;
    out_item_t  item_a;
    out_item_t  item_b;
  } res_push_t;

  function automatic logic [31:0] add_byte(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [1:0] idx, input logic le);
    logic [31:0] r;
    if (le) begin
      r = acc | ({24'd0, b} << {idx, 3'b000});
    end else begin
      r = {acc[23:0], b};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gpnwk_parse.sv =====
// ----------------------------------------------------------------------------
// gpnwk_parse
// Header state machine: walks one frame byte per step and forms result items.
// ----------------------------------------------------------------------------
module gpnwk_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  gpnwk_pkg::in_item_t  item_i,
  input  logic                 little_endian_i,
  output gpnwk_pkg::res_push_t res_o
);
  import gpnwk_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  fc_q, fc_d, ec_q, ec_d, cmd_q, cmd_d;
  logic [31:0] sid_q, sid_d, cnt_q, cnt_d;
  logic [2:0]  st_q, st_d;

  logic [7:0]  b, hdr_fc, hdr_ec;
  logic [2:0]  app;
  logic [1:0]  sec, ftype;
  logic        ext_flag, app_ok, need_src, need_cnt, need_cmd, fin, trunc;
  phase_e      ph_after_app, ph_after_src, ph_after_cnt;
  out_item_t   pay_item, sum_item;

  assign b        = item_i.data_byte;
  assign hdr_fc   = (phase_q == PhFc) ? b : fc_q;
  assign hdr_ec   = (phase_q == PhFc) ? 8'd0 : ((phase_q == PhExt) ? b : ec_q);
  assign app      = hdr_ec[2:0];
  assign sec      = hdr_ec[4:3];
  assign ftype    = hdr_fc[1:0];
  assign ext_flag = hdr_fc[ExtFlagBit];
  assign app_ok   = (app <= AppIdTwo);
  assign need_cmd = (app == AppIdZero) || (app == AppIdTwo);
  assign need_src = (app == AppIdZero) &&
                    ((ftype == GpDataFrame) || ((ftype == GpMaintFrame) && ext_flag));
  assign need_cnt = ext_flag && need_cmd && (sec >= SecLevelCounter);

  assign ph_after_cnt = need_cmd ? PhCmd : PhDone;
  assign ph_after_src = need_cnt ? PhCnt : ph_after_cnt;
  assign ph_after_app = !app_ok ? PhSkip : (need_src ? PhSrc : ph_after_src);

  // header walk
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    fc_d    = fc_q;
    ec_d    = ec_q;
    sid_d   = sid_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    st_d    = st_q;
    case (phase_q)
      PhFc: begin
        fc_d  = b;
        ec_d  = '0;
        sid_d = '0;
        cnt_d = '0;
        cmd_d = '0;
        idx_d = '0;
        st_d  = StatusOk;
        if (b[1:0] > GpMaintFrame) begin
          st_d    = StatusBadType;
          phase_d = PhSkip;
        end else if (b[3:2] != GpVersion) begin
          st_d    = StatusBadVer;
          phase_d = PhSkip;
        end else if (b[ExtFlagBit]) begin
          phase_d = PhExt;
        end else begin
          phase_d = ph_after_app;
          if (!app_ok) st_d = StatusBadApp;
        end
      end
      PhExt: begin
        ec_d    = b;
        phase_d = ph_after_app;
        idx_d   = '0;
        if (!app_ok) st_d = StatusBadApp;
      end
      PhSrc: begin
        sid_d = add_byte(sid_q, b, idx_q, little_endian_i);
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) phase_d = ph_after_src;
      end
      PhCnt: begin
        cnt_d = add_byte(cnt_q, b, idx_q, little_endian_i);
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) phase_d = ph_after_cnt;
      end
      PhCmd: begin
        cmd_d   = b;
        phase_d = PhPayload;
      end
      default: begin
      end
    endcase
  end

  // result items
  always_comb begin
    fin   = item_i.frame_end;
    trunc = (phase_d == PhExt) || (phase_d == PhSrc) ||
            (phase_d == PhCnt) || (phase_d == PhCmd);

    pay_item              = '0;
    pay_item.kind         = KindPayload;
    pay_item.payload_byte = b;

    sum_item               = '0;
    sum_item.kind          = KindSummary;
    sum_item.status        = trunc ? StatusTrunc : st_d;
    sum_item.frame_control = fc_d;
    sum_item.ext_control   = ec_d;
    sum_item.source_id     = (phase_d == PhSrc) ? 32'd0 : sid_d;
    sum_item.frame_counter = (phase_d == PhCnt) ? 32'd0 : cnt_d;
    sum_item.command_id    = cmd_d;

    res_o = '0;
    if (step_i) begin
      if (phase_q == PhPayload) begin
        res_o.item_a = pay_item;
        res_o.item_b = sum_item;
        res_o.num    = fin ? 2'd2 : 2'd1;
      end else if (fin) begin
        res_o.item_a = sum_item;
        res_o.num    = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFc;
      idx_q   <= '0;
      fc_q    <= '0;
      ec_q    <= '0;
      sid_q   <= '0;
      cnt_q   <= '0;
      cmd_q   <= '0;
      st_q    <= StatusOk;
    end else if (step_i) begin
      if (item_i.frame_end) begin
        phase_q <= PhFc;
        idx_q   <= '0;
        fc_q    <= '0;
        ec_q    <= '0;
        sid_q   <= '0;
        cnt_q   <= '0;
        cmd_q   <= '0;
        st_q    <= StatusOk;
      end else begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        fc_q    <= fc_d;
        ec_q    <= ec_d;
        sid_q   <= sid_d;
        cnt_q   <= cnt_d;
        cmd_q   <= cmd_d;
        st_q    <= st_d;
      end
    end
  end

  a_status_only_in_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StatusOk) |-> (phase_q == PhSkip))
    else $error("error status held outside skip phase");

  a_index_only_in_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> ((phase_q == PhSrc) || (phase_q == PhCnt)))
    else $error("byte index nonzero outside a multi-byte field");

  a_clear_after_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.frame_end) |=> (phase_q == PhFc && fc_q == 8'd0))
    else $error("frame state not cleared after summary");

endmodule

// ===== hw/rtl/gpnwk_resq.sv =====
// ----------------------------------------------------------------------------
// gpnwk_resq
// Result queue: takes up to two items per cycle, hands out one per cycle while not stalled.
// ----------------------------------------------------------------------------
module gpnwk_resq #(
  parameter int unsigned Depth = gpnwk_pkg::ResQDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpnwk_pkg::res_push_t push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gpnwk_pkg::out_item_t out_item_o
);
  import gpnwk_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q, wr_d, rd_d, wr_b;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_b        = ptr_inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);
    case (push_i.num)
      2'd1:    wr_d = wr_b;
      2'd2:    wr_d = ptr_inc(wr_b);
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.item_a;
    if (push_i.num == 2'd2) mem_q[wr_b] <= push_i.item_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue fill above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> room_o)
    else $error("push into result queue without room");

  a_pop_lowers_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.num == 2'd0) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("fill count not lowered by a lone pop");

endmodule

// ===== hw/rtl/gp_nwk_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// gp_nwk_frame_parser_top
// Green Power network frame parser, one byte per item.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while the input is not stalled. A byte is
// held in an input register, parsed combinationally by the header state
// machine, and its results (a payload item, an end-of-frame summary, or both
// for a last payload byte) are written into a four-entry result queue that
// drives the output port. An item passes through the input register and the
// result queue on its way from input to output. The input is stalled while
// the result queue holds more than two items. The byte order register may
// only be written while no frame is in flight.
module gp_nwk_frame_parser_top #(
  parameter int unsigned ResQDepth = gpnwk_pkg::ResQDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gpnwk_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gpnwk_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);
  import gpnwk_pkg::*;

  logic       in_vld_q, in_vld_d, accept, room, step, le_q;
  in_item_t   in_item_q;
  res_push_t  res;

  assign cfg_ready_o = 1'b1;
  assign step        = in_vld_q && room;
  assign in_stall_o  = in_vld_q && !room;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_vld_d    = accept || (in_vld_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      le_q     <= 1'b1;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_valid_i && cfg_ready_o) le_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_item_q <= in_item_i;
  end

  gpnwk_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (in_item_q),
    .little_endian_i (le_q),
    .res_o           (res)
  );

  gpnwk_resq #(
    .Depth (ResQDepth)
  ) u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
